// File: hw/rtl/lcm_pkg.sv
// Shared types and codes for the line/column mapper.
`timescale 1ns / 1ps
`default_nettype none

package lcm_pkg;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;
    typedef logic [7:0] t_byte;

    // Beat operation codes
    localparam t_mode MODE_CLEAR = 2'd0;
    localparam t_mode MODE_FEED  = 2'd1;
    localparam t_mode MODE_END   = 2'd2;
    localparam t_mode MODE_QUERY = 2'd3;

    // Result status codes
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BEYOND = 2'd1;
    localparam t_status ST_PHASE  = 2'd2;
    localparam t_status ST_OVF    = 2'd3;

    // Line break characters
    localparam t_byte CH_LF = 8'h0A;
    localparam t_byte CH_CR = 8'h0D;

endpackage

`default_nettype wire

// File: hw/rtl/line_column_mapper.sv
// Line start table with offset to line/column lookup.
//
// Feed a text one byte per beat (mode 1); LF or CR ends a line, and a directly
// following CR/LF of the other kind joins the same break. An end beat (mode 2)
// seals the text, a clear beat (mode 0) starts over, and a query beat (mode 3)
// maps an offset to its line and column. Every beat gives exactly one result.
// For clear, feed, end and every query that fails or hits a one-line text,
// the result is registered on the edge that accepts the beat. Other queries
// run a binary search over the line start memory through its single
// registered read port; each step is a read state, then a compare state.
// A new beat is taken once the search is done and the output register is
// empty or being drained in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module line_column_mapper #(
    parameter int MAX_LINES   = 1024,
    parameter int OFFSET_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  lcm_pkg::t_mode                   i_mode,
    input  lcm_pkg::t_byte                   i_text_byte,
    input  wire  [OFFSET_BITS-1:0]           i_query_offset,
    output logic                             o_valid,
    input  wire                              i_ready,
    output lcm_pkg::t_status                 o_status,
    output logic [$clog2(MAX_LINES)-1:0]     o_line_number,
    output logic [OFFSET_BITS-1:0]           o_column_number,
    output logic [$clog2(MAX_LINES+1)-1:0]   o_lines_so_far
);
    import lcm_pkg::*;

    localparam int LW = $clog2(MAX_LINES);
    localparam int TW = $clog2(MAX_LINES + 1);
    localparam logic [TW-1:0] MAX_TOTAL = TW'(MAX_LINES);
    localparam logic [TW-1:0] ONE_LINE  = TW'(1);
    localparam logic [OFFSET_BITS-1:0] BYTE_MAX = '1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    // Line start memory, entry 0 is implicitly zero and never read
    logic [OFFSET_BITS-1:0] r_mem [MAX_LINES];

    logic [1:0]             r_state, n_state;
    logic                   r_out_valid, n_out_valid;
    logic [TW-1:0]          r_line_total, n_line_total;
    logic [OFFSET_BITS-1:0] r_byte_total, n_byte_total;
    logic                   r_brk_pend, n_brk_pend;
    logic                   r_pend_cr, n_pend_cr;
    logic                   r_sealed, n_sealed;
    logic                   r_ovf, n_ovf;

    logic [LW-1:0]          r_lo, n_lo;
    logic [LW-1:0]          r_hi, n_hi;
    logic [LW-1:0]          r_mid, n_mid;
    logic [OFFSET_BITS-1:0] r_lo_start, n_lo_start;
    logic [OFFSET_BITS-1:0] r_q, n_q;
    logic [OFFSET_BITS-1:0] r_rd_data;

    t_status                r_status, n_status;
    logic [LW-1:0]          r_line, n_line;
    logic [OFFSET_BITS-1:0] r_col, n_col;
    logic [TW-1:0]          r_lines, n_lines;

    logic                   w_in_fire;
    logic                   w_is_cr;
    logic                   w_is_brk;
    logic [OFFSET_BITS-1:0] w_next_byte;
    logic [TW-1:0]          w_tot_m1;
    logic [LW:0]            w_mid_sum;
    logic [LW-1:0]          w_mid;
    logic                   w_wr_en;
    logic [LW-1:0]          w_wr_idx;
    logic                   w_load;
    t_status                w_ld_status;
    logic [LW-1:0]          v_lo;
    logic [LW-1:0]          v_hi;
    logic [OFFSET_BITS-1:0] v_lo_start;

    assign o_ready   = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_in_fire = i_valid && o_ready;

    assign w_is_cr     = (i_text_byte == CH_CR);
    assign w_is_brk    = w_is_cr || (i_text_byte == CH_LF);
    assign w_next_byte = r_byte_total + 1'b1;
    assign w_tot_m1    = r_line_total - ONE_LINE;

    // Upper middle of the search window
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + 1'b1;
    assign w_mid     = w_mid_sum[LW:1];

    // Next state, table writes and result loading
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_line_total = r_line_total;
        n_byte_total = r_byte_total;
        n_brk_pend   = r_brk_pend;
        n_pend_cr    = r_pend_cr;
        n_sealed     = r_sealed;
        n_ovf        = r_ovf;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_lo_start   = r_lo_start;
        n_q          = r_q;
        n_status     = r_status;
        n_line       = r_line;
        n_col        = r_col;
        n_lines      = r_lines;
        w_wr_en      = 1'b0;
        w_wr_idx     = r_line_total[LW-1:0];
        w_load       = 1'b0;
        w_ld_status  = ST_OK;
        v_lo         = r_lo;
        v_hi         = r_hi;
        v_lo_start   = r_lo_start;

        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_line_total = ONE_LINE;
                            n_byte_total = '0;
                            n_brk_pend   = 1'b0;
                            n_pend_cr    = 1'b0;
                            n_sealed     = 1'b0;
                            n_ovf        = 1'b0;
                            w_load       = 1'b1;
                            w_ld_status  = ST_OK;
                        end
                        MODE_FEED: begin
                            w_load = 1'b1;
                            if (r_sealed) begin
                                w_ld_status = ST_PHASE;
                            end else if (r_byte_total == BYTE_MAX) begin
                                n_ovf       = 1'b1;
                                w_ld_status = ST_OVF;
                            end else begin
                                n_byte_total = w_next_byte;
                                if (w_is_brk && r_brk_pend && (r_pend_cr != w_is_cr)) begin
                                    // second half of a pair: move the open line's start
                                    w_wr_en    = 1'b1;
                                    w_wr_idx   = w_tot_m1[LW-1:0];
                                    n_brk_pend = 1'b0;
                                end else if (w_is_brk) begin
                                    if (r_line_total >= MAX_TOTAL) begin
                                        n_ovf      = 1'b1;
                                        n_brk_pend = 1'b0;
                                    end else begin
                                        w_wr_en      = 1'b1;
                                        n_line_total = r_line_total + ONE_LINE;
                                        n_brk_pend   = 1'b1;
                                        n_pend_cr    = w_is_cr;
                                    end
                                end else begin
                                    n_brk_pend = 1'b0;
                                end
                                w_ld_status = n_ovf ? ST_OVF : ST_OK;
                            end
                        end
                        MODE_END: begin
                            w_load = 1'b1;
                            if (r_sealed) begin
                                w_ld_status = ST_PHASE;
                            end else begin
                                n_sealed    = 1'b1;
                                n_brk_pend  = 1'b0;
                                w_ld_status = r_ovf ? ST_OVF : ST_OK;
                            end
                        end
                        default: begin
                            if (!r_sealed) begin
                                w_load      = 1'b1;
                                w_ld_status = ST_PHASE;
                            end else if (i_query_offset > r_byte_total) begin
                                w_load      = 1'b1;
                                w_ld_status = ST_BEYOND;
                            end else if (r_line_total == ONE_LINE) begin
                                // single line: answer at once
                                n_out_valid = 1'b1;
                                n_status    = r_ovf ? ST_OVF : ST_OK;
                                n_line      = '0;
                                n_col       = i_query_offset;
                                n_lines     = r_line_total;
                            end else begin
                                n_lo       = '0;
                                n_hi       = w_tot_m1[LW-1:0];
                                n_lo_start = '0;
                                n_q        = i_query_offset;
                                n_state    = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                // issue the memory read at the window middle
                n_mid   = w_mid;
                n_state = S_CMP;
            end
            S_CMP: begin
                // narrow the window on the returned start
                if (r_rd_data <= r_q) begin
                    v_lo       = r_mid;
                    v_lo_start = r_rd_data;
                end else begin
                    v_hi = r_mid - 1'b1;
                end
                n_lo       = v_lo;
                n_hi       = v_hi;
                n_lo_start = v_lo_start;
                if (v_lo == v_hi) begin
                    n_out_valid = 1'b1;
                    n_status    = r_ovf ? ST_OVF : ST_OK;
                    n_line      = v_lo;
                    n_col       = r_q - v_lo_start;
                    n_lines     = r_line_total;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // load a direct result (no search) with zero line and column
        if (w_load) begin
            n_out_valid = 1'b1;
            n_status    = w_ld_status;
            n_line      = '0;
            n_col       = '0;
            n_lines     = n_line_total;
        end
    end

    // Write new line starts, read the search probe
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_next_byte;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[w_mid];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_line_total <= ONE_LINE;
            r_byte_total <= '0;
            r_brk_pend   <= 1'b0;
            r_pend_cr    <= 1'b0;
            r_sealed     <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_line_total <= n_line_total;
            r_byte_total <= n_byte_total;
            r_brk_pend   <= n_brk_pend;
            r_pend_cr    <= n_pend_cr;
            r_sealed     <= n_sealed;
            r_ovf        <= n_ovf;
        end
    end

    // Search window and result payload
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_lo_start <= n_lo_start;
        r_q        <= n_q;
        r_status   <= n_status;
        r_line     <= n_line;
        r_col      <= n_col;
        r_lines    <= n_lines;
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_line_number   = r_line;
    assign o_column_number = r_col;
    assign o_lines_so_far  = r_lines;

endmodule

`default_nettype wire

// File: hw/rtl/lcm_checker.sv
// Port-level assertions for the line/column mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lcm_checker #(
    parameter int MAX_LINES   = 1024,
    parameter int OFFSET_BITS = 16
) (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              o_ready,
    input lcm_pkg::t_mode                   i_mode,
    input wire                              o_valid,
    input wire                              i_ready,
    input lcm_pkg::t_status                 o_status,
    input wire  [$clog2(MAX_LINES)-1:0]     o_line_number,
    input wire  [OFFSET_BITS-1:0]           o_column_number,
    input wire  [$clog2(MAX_LINES+1)-1:0]   o_lines_so_far
);
    import lcm_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_lines_so_far))
        else $error("result beat dropped or changed while stalled");

    // Answer a clear beat on the next edge with a fresh single-line text
    a_clear_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_mode == MODE_CLEAR) |=>
        o_valid && (o_status == ST_OK) && (o_lines_so_far == 1) &&
        (o_line_number == 0) && (o_column_number == 0))
        else $error("clear beat not answered with a fresh text");

    // Zero line and column on phase and range failures
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_status == ST_PHASE) || (o_status == ST_BEYOND)) |->
        (o_line_number == 0) && (o_column_number == 0))
        else $error("failed result carries a line or column");

    // Keep at least one line and place the line inside the count
    a_line_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lines_so_far != 0) &&
        ({1'b0, o_line_number} < o_lines_so_far))
        else $error("line index outside the recorded lines");

    // Take no new beat while a stalled result waits
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while result is stalled");

endmodule

bind line_column_mapper lcm_checker #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
) u_lcm_checker (.*);

`default_nettype wire
